[rtl/lrbo_pkg.sv]
`default_nettype none
package lrbo_pkg;

  // Store geometry.
  localparam int unsigned BufferBytes = 4096;
  localparam int unsigned AddrW       = $clog2(BufferBytes);
  localparam int unsigned FillW       = AddrW + 1;

  // Read requests are limited to this many bytes.
  localparam int unsigned MaxRead = 64;
  localparam int unsigned CountW  = 7;

  // Depth of the command queue between the front and the back.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // Input kinds.
  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_READ  = 1'b1
  } kind_e;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_WRITTEN = 3'd0,
    ST_DROPPED = 3'd1,
    ST_REFUSED = 3'd2,
    ST_READ    = 3'd3,
    ST_EMPTY   = 3'd4
  } status_e;

  // Back-end sequencer states.
  typedef enum logic {
    BK_IDLE  = 1'b0,
    BK_DRAIN = 1'b1
  } back_state_e;

  // One classified command as it travels through the queue.
  typedef struct packed {
    kind_e             kind;
    logic [7:0]        data_byte;
    logic [CountW-1:0] count;
  } cmd_t;

endpackage
`default_nettype wire

[rtl/lrbo_front.sv]
`default_nettype none
module lrbo_front (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       in_valid_i,
  output logic                      in_ready_o,
  input  wire                       kind_i,
  input  wire  [7:0]                data_byte_i,
  input  wire  [lrbo_pkg::CountW-1:0] read_count_i,
  output logic                      cmd_valid_o,
  input  wire                       cmd_pop_i,
  output lrbo_pkg::cmd_t            cmd_o
);
  import lrbo_pkg::*;

  cmd_t                 slot_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] cnt_q, cnt_d;
  cmd_t                 cmd_new;
  logic                 push;
  logic                 pop;

  // Classify the incoming beat and saturate the read count.
  always_comb begin
    cmd_new.kind      = kind_e'(kind_i);
    cmd_new.data_byte = data_byte_i;
    if (read_count_i > CountW'(MaxRead)) begin
      cmd_new.count = CountW'(MaxRead);
    end else begin
      cmd_new.count = read_count_i;
    end
  end

  // Queue handshake on both sides.
  assign in_ready_o  = (cnt_q != QueueCntW'(QueueDepth));
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = slot_q[rd_ptr_q];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue slots hold payload only.
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule
`default_nettype wire

[rtl/lrbo_back.sv]
`default_nettype none
module lrbo_back (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         cfg_we_i,
  input  wire                         cfg_wdata_i,
  input  wire                         cmd_valid_i,
  output logic                        cmd_pop_o,
  input  lrbo_pkg::cmd_t              cmd_i,
  output logic                        out_valid_o,
  input  wire                         out_ready_i,
  output lrbo_pkg::status_e           status_o,
  output logic [7:0]                  data_out_o,
  output logic                        last_o,
  output logic [lrbo_pkg::FillW-1:0]  fill_level_o
);
  import lrbo_pkg::*;

  back_state_e       state_q, state_d;
  logic [AddrW-1:0]  head_q, head_d;
  logic [FillW-1:0]  fill_q, fill_d;
  logic [CountW-1:0] rem_q, rem_d;
  logic              blocking_q;

  logic              out_valid_q, out_valid_d;
  status_e           status_q, status_d;
  logic [7:0]        data_q, data_d;
  logic              last_q, last_d;
  logic [FillW-1:0]  level_q, level_d;

  logic [7:0]        mem [BufferBytes];
  logic [7:0]        rdata_q;
  logic              mem_we, mem_re;
  logic [AddrW-1:0]  mem_wa, mem_ra;

  logic              out_free;
  logic              start;
  logic [CountW-1:0] take;

  // The output register can be loaded when empty or draining this cycle.
  assign out_free = !out_valid_q || out_ready_i;
  assign start    = (state_q == BK_IDLE) && cmd_valid_i && out_free;

  // Bytes actually drained by a read command: the request capped by the fill.
  assign take = (FillW'(cmd_i.count) > fill_q) ? fill_q[CountW-1:0] : cmd_i.count;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (start && (cmd_i.kind == KIND_READ) && (take != '0)) begin
          state_d = BK_DRAIN;
        end
      end
      BK_DRAIN: begin
        if (out_free && (rem_q == CountW'(1))) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Datapath, store access and result formation.
  always_comb begin
    head_d      = head_q;
    fill_d      = fill_q;
    rem_d       = rem_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    data_d      = data_q;
    last_d      = last_q;
    level_d     = level_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_wa      = head_q + fill_q[AddrW-1:0];
    mem_ra      = head_q;
    cmd_pop_o   = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (start) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.kind == KIND_WRITE) begin
            out_valid_d = 1'b1;
            data_d      = '0;
            last_d      = 1'b1;
            if (fill_q < FillW'(BufferBytes)) begin
              // Append at the tail.
              mem_we   = 1'b1;
              fill_d   = fill_q + 1'b1;
              status_d = ST_WRITTEN;
              level_d  = fill_q + 1'b1;
            end else if (blocking_q) begin
              status_d = ST_REFUSED;
              level_d  = fill_q;
            end else begin
              // Full: the tail is the head slot, so overwrite the oldest byte.
              mem_we   = 1'b1;
              mem_wa   = head_q;
              head_d   = head_q + 1'b1;
              status_d = ST_DROPPED;
              level_d  = fill_q;
            end
          end else if (take == '0) begin
            out_valid_d = 1'b1;
            status_d    = ST_EMPTY;
            data_d      = '0;
            last_d      = 1'b1;
            level_d     = fill_q;
          end else begin
            // Prefetch the byte at the head for the first result.
            mem_re = 1'b1;
            rem_d  = take;
          end
        end
      end
      BK_DRAIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          status_d    = ST_READ;
          data_d      = rdata_q;
          last_d      = (rem_q == CountW'(1));
          level_d     = fill_q - 1'b1;
          fill_d      = fill_q - 1'b1;
          head_d      = head_q + 1'b1;
          rem_d       = rem_q - 1'b1;
          if (rem_q != CountW'(1)) begin
            mem_re = 1'b1;
            mem_ra = head_q + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      head_q      <= '0;
      fill_q      <= '0;
      rem_q       <= '0;
      blocking_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      fill_q      <= fill_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        blocking_q <= cfg_wdata_i;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    data_q   <= data_d;
    last_q   <= last_d;
    level_q  <= level_d;
  end

  // Byte store with one write and one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= cmd_i.data_byte;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_ra];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign data_out_o   = data_q;
  assign last_o       = last_q;
  assign fill_level_o = level_q;

endmodule
`default_nettype wire

[rtl/log_ring_buffer_overwrite_unit.sv]
`default_nettype none
// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_ready_o   kind_i, data_byte_i, read_count_i
// out       output     out_valid_o / out_ready_i status_o, data_out_o, last_o, fill_level_o
// cfg       input      cfg_we_i                  cfg_wdata_i (blocking mode)
//
// A write beat waits in a slot of the two-entry command queue; its result is registered on
// the edge that pops it from the queue.
// A read beat of n bytes drains the smaller of n and the fill: the back end first fetches the
// head byte from the store, then returns one byte per cycle while the output is taken.
// Reset clears head, fill, mode and queue; the byte store is not cleared.
// A stalled output holds the back end; the queue keeps accepting until it is full.
module log_ring_buffer_overwrite_unit (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           cfg_we_i,
  input  wire                           cfg_wdata_i,
  input  wire                           in_valid_i,
  output logic                          in_ready_o,
  input  wire                           kind_i,
  input  wire  [7:0]                    data_byte_i,
  input  wire  [lrbo_pkg::CountW-1:0]   read_count_i,
  output logic                          out_valid_o,
  input  wire                           out_ready_i,
  output logic [2:0]                    status_o,
  output logic [7:0]                    data_out_o,
  output logic                          last_o,
  output logic [lrbo_pkg::FillW-1:0]    fill_level_o
);
  import lrbo_pkg::*;

  logic    cmd_valid;
  logic    cmd_pop;
  cmd_t    cmd;
  status_e status;

  // Front: accepts beats and queues classified commands.
  lrbo_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .data_byte_i  (data_byte_i),
    .read_count_i (read_count_i),
    .cmd_valid_o  (cmd_valid),
    .cmd_pop_i    (cmd_pop),
    .cmd_o        (cmd)
  );

  // Back: owns the store, pointers and the result register.
  lrbo_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .cmd_valid_i  (cmd_valid),
    .cmd_pop_o    (cmd_pop),
    .cmd_i        (cmd),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status),
    .data_out_o   (data_out_o),
    .last_o       (last_o),
    .fill_level_o (fill_level_o)
  );

  assign status_o = status;

  // The fill level never passes the store size.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (fill_level_o <= FillW'(BufferBytes)))
    else $error("fill level above store size");

  // Every result of a write or an empty read closes its item.
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_READ)) |-> last_o)
    else $error("single result without last");

  // A queued command is not lost before the back end takes it.
  a_cmd_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid && !cmd_pop) |=> (cmd_valid && $stable(cmd)))
    else $error("queued command changed before pop");

  // A drained byte lowers the fill level by one on the next byte.
  a_drain_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && (status_o == ST_READ) && !last_o)
      ##1 out_valid_o |-> (fill_level_o == $past(fill_level_o) - 1'b1))
    else $error("fill level did not step during a read");

endmodule
`default_nettype wire
